/* src/somo_pkg.sv */
// ----------------------------------------------------------------------------
// Momentum observer package
// Shared widths, constants, multiply request types and saturation helpers.
// ----------------------------------------------------------------------------
package somo_pkg;

  // Channel count and field widths
  localparam int CHANNELS   = 3;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int STATE_W    = 48;
  localparam int DATA_W     = 32;
  localparam int FREQ_W     = 16;
  localparam int DAMP_W     = 12;
  localparam int DT_W       = 24;
  localparam int DT_CLAMP_W = 20;
  localparam int GAIN_W     = 32;
  localparam int K2_W       = 29;
  localparam int CFG_IDX_W  = 3;

  // Register map: natural frequencies first, then damping ratios
  localparam int CFG_FREQ_BASE = 0;
  localparam int CFG_DAMP_BASE = CHANNELS;

  // Reset values: 10.0 rad/s in Q8.8, damping 1.5 in Q4.8
  localparam logic [FREQ_W-1:0] FREQ_RESET = 16'd2560;
  localparam logic [DAMP_W-1:0] DAMP_RESET = 12'd384;

  // Step time limits, 1e-6 s and 0.05 s in Q0.24
  localparam logic [DT_W-1:0] DT_MIN = 24'd17;
  localparam logic [DT_W-1:0] DT_MAX = 24'd838861;

  // Signed 48 bit limits and the magnitude clamp of the multiply unit
  localparam logic [STATE_W-1:0] S48_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [STATE_W-1:0] S48_MIN = 48'h8000_0000_0000;
  localparam logic [STATE_W-1:0] MAG_LIM = 48'h8000_0000_0000;

  // Right shift applied after a product
  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_16 = 2'd1,
    SH_24 = 2'd2
  } shift_e;

  // Request to the shared multiply unit
  typedef struct packed {
    logic               start;
    logic [STATE_W-1:0] a;
    logic [GAIN_W-1:0]  b;
    shift_e             sh;
  } mul_req_t;

  // Response of the shared multiply unit
  typedef struct packed {
    logic               done;
    logic [STATE_W-1:0] res;
  } mul_rsp_t;

  // Saturate a 49 bit two's complement value to 48 bits
  function automatic logic [STATE_W-1:0] sat48(input logic [STATE_W:0] v);
    logic [STATE_W-1:0] r;
    if (v[STATE_W] != v[STATE_W-1]) begin
      r = v[STATE_W] ? S48_MIN : S48_MAX;
    end else begin
      r = v[STATE_W-1:0];
    end
    return r;
  endfunction

  // Saturate a 49 bit two's complement value to 32 bits
  function automatic logic [DATA_W-1:0] sat32(input logic [STATE_W:0] v);
    logic [DATA_W-1:0] r;
    if ((v[STATE_W:DATA_W-1] == '0) || (v[STATE_W:DATA_W-1] == '1)) begin
      r = v[DATA_W-1:0];
    end else begin
      r = v[STATE_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  // Sign extend a Q16.16 word to the 48 bit state format
  function automatic logic [STATE_W-1:0] sext(input logic [DATA_W-1:0] v);
    return {{(STATE_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

endpackage

/* src/somo_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Momentum observer configuration registers
// Per-channel natural frequency and damping ratio, written one word at a time.
// ----------------------------------------------------------------------------
module somo_cfg_regs (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 cfg_valid_i,
  output logic                                                 cfg_ready_o,
  input  logic [somo_pkg::CFG_IDX_W-1:0]                       cfg_index_i,
  input  logic [somo_pkg::FREQ_W-1:0]                          cfg_data_i,
  output logic [somo_pkg::CHANNELS-1:0][somo_pkg::FREQ_W-1:0]  freq_o,
  output logic [somo_pkg::CHANNELS-1:0][somo_pkg::DAMP_W-1:0]  damp_o
);

  logic [somo_pkg::CHANNELS-1:0][somo_pkg::FREQ_W-1:0] freq_q;
  logic [somo_pkg::CHANNELS-1:0][somo_pkg::DAMP_W-1:0] damp_q;
  logic                                                wr_en;

  // Always take the word; the user must write only while idle (not enforced)
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  // Decode the index; indexes past the map are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < somo_pkg::CHANNELS; i++) begin
        freq_q[i] <= somo_pkg::FREQ_RESET;
        damp_q[i] <= somo_pkg::DAMP_RESET;
      end
    end else if (wr_en) begin
      for (int i = 0; i < somo_pkg::CHANNELS; i++) begin
        if (cfg_index_i == somo_pkg::CFG_IDX_W'(somo_pkg::CFG_FREQ_BASE + i)) begin
          freq_q[i] <= cfg_data_i;
        end
        if (cfg_index_i == somo_pkg::CFG_IDX_W'(somo_pkg::CFG_DAMP_BASE + i)) begin
          damp_q[i] <= cfg_data_i[somo_pkg::DAMP_W-1:0];
        end
      end
    end
  end

  assign freq_o = freq_q;
  assign damp_o = damp_q;

endmodule

/* src/somo_mul_unit.sv */
// ----------------------------------------------------------------------------
// Momentum observer multiply unit
// Shared 24x32 multiplier: |a| * b over two partial products, right shift,
// magnitude clamp and sign restore, truncating toward zero.
// ----------------------------------------------------------------------------
module somo_mul_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  somo_pkg::mul_req_t req_i,
  output somo_pkg::mul_rsp_t rsp_o
);

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_HI   = 5'b00010,
    M_LO   = 5'b00100,
    M_SUM  = 5'b01000,
    M_NEG  = 5'b10000
  } mstate_e;

  localparam int HALF_W = somo_pkg::STATE_W / 2;
  localparam int PROD_W = HALF_W + somo_pkg::GAIN_W;
  localparam int FULL_W = PROD_W + HALF_W;

  mstate_e                        state_q, state_d;
  logic                           done_q;
  logic                           neg_q;
  logic [somo_pkg::STATE_W-1:0]   m_q;
  logic [somo_pkg::GAIN_W-1:0]    b_q;
  somo_pkg::shift_e               sh_q;
  logic [PROD_W-1:0]              hi_q;
  logic [PROD_W-1:0]              lo_q;
  logic [somo_pkg::STATE_W-1:0]   mag_q;
  logic [somo_pkg::STATE_W-1:0]   res_q;

  logic [somo_pkg::STATE_W-1:0]   a_mag;
  logic [HALF_W-1:0]              mul_op;
  logic [PROD_W-1:0]              prod;
  logic [FULL_W-1:0]              full;
  logic [FULL_W-1:0]              shifted;
  logic [somo_pkg::STATE_W-1:0]   mag_c;
  logic [somo_pkg::STATE_W-1:0]   res_c;

  // Magnitude of the operand; the most negative value maps to 2^47
  assign a_mag = req_i.a[somo_pkg::STATE_W-1] ? (~req_i.a + 48'd1) : req_i.a;

  // One multiplier, upper half first, then lower half
  assign mul_op = (state_q == M_HI) ? m_q[somo_pkg::STATE_W-1:HALF_W] : m_q[HALF_W-1:0];
  assign prod   = {{somo_pkg::GAIN_W{1'b0}}, mul_op} * {{HALF_W{1'b0}}, b_q};

  // Recombine partial products, shift and clamp the magnitude
  assign full = {hi_q, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, lo_q};

  always_comb begin
    case (sh_q)
      somo_pkg::SH_16: shifted = full >> 16;
      somo_pkg::SH_24: shifted = full >> 24;
      default:         shifted = full;
    endcase
    if (shifted > {{(FULL_W-somo_pkg::STATE_W){1'b0}}, somo_pkg::MAG_LIM}) begin
      mag_c = somo_pkg::MAG_LIM;
    end else begin
      mag_c = shifted[somo_pkg::STATE_W-1:0];
    end
  end

  // Restore the sign; a positive 2^47 saturates to the 48 bit maximum
  always_comb begin
    if (neg_q) begin
      res_c = ~mag_q + 48'd1;
    end else if (mag_q == somo_pkg::MAG_LIM) begin
      res_c = somo_pkg::S48_MAX;
    end else begin
      res_c = mag_q;
    end
  end

  // Sequence the steps of one product
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      M_IDLE:  if (req_i.start) begin
        state_d = M_HI;
      end
      M_HI:    state_d = M_LO;
      M_LO:    state_d = M_SUM;
      M_SUM:   state_d = M_NEG;
      M_NEG:   state_d = M_IDLE;
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == M_NEG);
    end
  end

  // Operand capture and datapath registers
  always_ff @(posedge clk_i) begin
    if ((state_q == M_IDLE) && req_i.start) begin
      neg_q <= req_i.a[somo_pkg::STATE_W-1];
      m_q   <= a_mag;
      b_q   <= req_i.b;
      sh_q  <= req_i.sh;
    end
    if (state_q == M_HI) begin
      hi_q <= prod;
    end
    if (state_q == M_LO) begin
      lo_q <= prod;
    end
    if (state_q == M_SUM) begin
      mag_q <= mag_c;
    end
    if (state_q == M_NEG) begin
      res_q <= res_c;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

/* src/somo_seq.sv */
// ----------------------------------------------------------------------------
// Momentum observer sequencer
// Holds the filter state and steps both filters of every channel through the
// shared multiply unit, one operation at a time.
// ----------------------------------------------------------------------------
module somo_seq (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 start_i,
  input  logic [somo_pkg::CHANNELS-1:0][somo_pkg::DATA_W-1:0]  momentum_i,
  input  logic [somo_pkg::CHANNELS-1:0][somo_pkg::DATA_W-1:0]  known_i,
  input  logic [somo_pkg::DT_W-1:0]                            step_time_i,
  input  logic [somo_pkg::CHANNELS-1:0][somo_pkg::FREQ_W-1:0]  freq_i,
  input  logic [somo_pkg::CHANNELS-1:0][somo_pkg::DAMP_W-1:0]  damp_i,
  output somo_pkg::mul_req_t                                   mul_req_o,
  input  somo_pkg::mul_rsp_t                                   mul_rsp_i,
  output logic                                                 idle_o,
  output logic                                                 res_valid_o,
  input  logic                                                 res_ready_i,
  output logic [somo_pkg::CHANNELS-1:0][somo_pkg::DATA_W-1:0]  est_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,
    S_WAIT  = 7'b0000100,
    S_LOAD  = 7'b0001000,
    S_ERR   = 7'b0010000,
    S_STORE = 7'b0100000,
    S_DONE  = 7'b1000000
  } sstate_e;

  // Operation handed to the multiply unit
  typedef enum logic [2:0] {
    OP_WN2       = 3'd0,
    OP_K2        = 3'd1,
    OP_ERR_GAIN  = 3'd2,
    OP_RATE_GAIN = 3'd3,
    OP_ACC_DT    = 3'd4,
    OP_RATE_DT   = 3'd5
  } op_e;

  localparam int SW = somo_pkg::STATE_W;

  sstate_e                       state_q, state_d;
  op_e                           op_q, op_d;
  logic [somo_pkg::CH_W-1:0]     ch_q, ch_d;
  logic                          filt_q, filt_d;
  logic                          primed_q, primed_d;

  // Filter state per channel
  logic [SW-1:0]                 mpos_q  [somo_pkg::CHANNELS];
  logic [SW-1:0]                 mrate_q [somo_pkg::CHANNELS];
  logic [SW-1:0]                 ipos_q  [somo_pkg::CHANNELS];
  logic [SW-1:0]                 irate_q [somo_pkg::CHANNELS];
  logic [somo_pkg::DATA_W-1:0]   est_q   [somo_pkg::CHANNELS];

  // Captured sample
  logic [somo_pkg::DATA_W-1:0]   mom_q   [somo_pkg::CHANNELS];
  logic [somo_pkg::DATA_W-1:0]   kn_q    [somo_pkg::CHANNELS];
  logic [somo_pkg::DT_CLAMP_W-1:0] dt_q;

  // Working registers of the current filter
  logic [somo_pkg::GAIN_W-1:0]   wn2_q;
  logic [somo_pkg::K2_W-1:0]     k2_q;
  logic [SW-1:0]                 pos_q;
  logic [SW-1:0]                 rate_q;
  logic [SW-1:0]                 drive_q;
  logic [SW-1:0]                 x_q;
  logic [SW-1:0]                 t_q;

  logic [somo_pkg::DT_W-1:0]     dt_clamp;
  logic [SW-1:0]                 mrate_cur;
  logic                          last_ch;

  assign last_ch   = (ch_q == somo_pkg::CH_W'(somo_pkg::CHANNELS - 1));
  assign mrate_cur = mrate_q[ch_q];

  // Clamp the step time to its legal range
  always_comb begin
    if (step_time_i < somo_pkg::DT_MIN) begin
      dt_clamp = somo_pkg::DT_MIN;
    end else if (step_time_i > somo_pkg::DT_MAX) begin
      dt_clamp = somo_pkg::DT_MAX;
    end else begin
      dt_clamp = step_time_i;
    end
  end

  // Select operands for the multiply unit
  always_comb begin
    mul_req_o.start = (state_q == S_MUL);
    case (op_q)
      OP_WN2: begin
        mul_req_o.a  = {{(SW-somo_pkg::FREQ_W){1'b0}}, freq_i[ch_q]};
        mul_req_o.b  = {{(somo_pkg::GAIN_W-somo_pkg::FREQ_W){1'b0}}, freq_i[ch_q]};
        mul_req_o.sh = somo_pkg::SH_0;
      end
      OP_K2: begin
        mul_req_o.a  = {{(SW-somo_pkg::DAMP_W){1'b0}}, damp_i[ch_q]};
        mul_req_o.b  = {{(somo_pkg::GAIN_W-somo_pkg::FREQ_W){1'b0}}, freq_i[ch_q]};
        mul_req_o.sh = somo_pkg::SH_0;
      end
      OP_ERR_GAIN: begin
        mul_req_o.a  = x_q;
        mul_req_o.b  = wn2_q;
        mul_req_o.sh = somo_pkg::SH_16;
      end
      OP_RATE_GAIN: begin
        mul_req_o.a  = rate_q;
        mul_req_o.b  = {{(somo_pkg::GAIN_W-somo_pkg::K2_W){1'b0}}, k2_q};
        mul_req_o.sh = somo_pkg::SH_16;
      end
      OP_ACC_DT: begin
        mul_req_o.a  = x_q;
        mul_req_o.b  = {{(somo_pkg::GAIN_W-somo_pkg::DT_CLAMP_W){1'b0}}, dt_q};
        mul_req_o.sh = somo_pkg::SH_24;
      end
      OP_RATE_DT: begin
        mul_req_o.a  = rate_q;
        mul_req_o.b  = {{(somo_pkg::GAIN_W-somo_pkg::DT_CLAMP_W){1'b0}}, dt_q};
        mul_req_o.sh = somo_pkg::SH_24;
      end
      default: begin
        mul_req_o.a  = x_q;
        mul_req_o.b  = wn2_q;
        mul_req_o.sh = somo_pkg::SH_0;
      end
    endcase
  end

  // Advance through gains, then both filters of each channel
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    ch_d     = ch_q;
    filt_d   = filt_q;
    primed_d = primed_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          primed_d = 1'b1;
          if (primed_q) begin
            state_d = S_MUL;
            op_d    = OP_WN2;
            ch_d    = '0;
            filt_d  = 1'b0;
          end
        end
      end
      S_MUL: state_d = S_WAIT;
      S_WAIT: begin
        if (mul_rsp_i.done) begin
          case (op_q)
            OP_WN2: begin
              op_d    = OP_K2;
              state_d = S_MUL;
            end
            OP_K2:        state_d = S_LOAD;
            OP_ERR_GAIN: begin
              op_d    = OP_RATE_GAIN;
              state_d = S_MUL;
            end
            OP_RATE_GAIN: begin
              op_d    = OP_ACC_DT;
              state_d = S_MUL;
            end
            OP_ACC_DT: begin
              op_d    = OP_RATE_DT;
              state_d = S_MUL;
            end
            OP_RATE_DT:   state_d = S_STORE;
            default:      state_d = S_IDLE;
          endcase
        end
      end
      S_LOAD: state_d = S_ERR;
      S_ERR: begin
        op_d    = OP_ERR_GAIN;
        state_d = S_MUL;
      end
      S_STORE: begin
        if (!filt_q) begin
          filt_d  = 1'b1;
          state_d = S_LOAD;
        end else if (last_ch) begin
          state_d = S_DONE;
        end else begin
          ch_d    = ch_q + somo_pkg::CH_W'(1);
          filt_d  = 1'b0;
          op_d    = OP_WN2;
          state_d = S_MUL;
        end
      end
      S_DONE: if (res_ready_i) begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= OP_WN2;
      ch_q     <= '0;
      filt_q   <= 1'b0;
      primed_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      ch_q     <= ch_d;
      filt_q   <= filt_d;
      primed_q <= primed_d;
    end
  end

  // Datapath: capture, prime, saturating adds and write back
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && start_i) begin
      for (int i = 0; i < somo_pkg::CHANNELS; i++) begin
        mom_q[i] <= momentum_i[i];
        kn_q[i]  <= known_i[i];
      end
      dt_q <= dt_clamp[somo_pkg::DT_CLAMP_W-1:0];
      // First word only seeds the momentum filter position
      if (!primed_q) begin
        for (int i = 0; i < somo_pkg::CHANNELS; i++) begin
          mpos_q[i]  <= somo_pkg::sext(momentum_i[i]);
          mrate_q[i] <= '0;
          ipos_q[i]  <= '0;
          irate_q[i] <= '0;
        end
      end
    end

    if ((state_q == S_WAIT) && mul_rsp_i.done) begin
      case (op_q)
        OP_WN2:       wn2_q  <= mul_rsp_i.res[somo_pkg::GAIN_W-1:0];
        OP_K2:        k2_q   <= {mul_rsp_i.res[somo_pkg::K2_W-2:0], 1'b0};
        OP_ERR_GAIN:  t_q    <= mul_rsp_i.res;
        OP_RATE_GAIN: x_q    <= somo_pkg::sat48({t_q[SW-1], t_q}
                                 - {mul_rsp_i.res[SW-1], mul_rsp_i.res});
        OP_ACC_DT:    rate_q <= somo_pkg::sat48({rate_q[SW-1], rate_q}
                                 + {mul_rsp_i.res[SW-1], mul_rsp_i.res});
        OP_RATE_DT:   pos_q  <= somo_pkg::sat48({pos_q[SW-1], pos_q}
                                 + {mul_rsp_i.res[SW-1], mul_rsp_i.res});
        default: ;
      endcase
    end

    if (state_q == S_LOAD) begin
      if (filt_q) begin
        pos_q   <= ipos_q[ch_q];
        rate_q  <= irate_q[ch_q];
        drive_q <= somo_pkg::sext(kn_q[ch_q]);
      end else begin
        pos_q   <= mpos_q[ch_q];
        rate_q  <= mrate_q[ch_q];
        drive_q <= somo_pkg::sext(mom_q[ch_q]);
      end
    end

    // Position error drives the filter
    if (state_q == S_ERR) begin
      x_q <= somo_pkg::sat48({drive_q[SW-1], drive_q} - {pos_q[SW-1], pos_q});
    end

    if (state_q == S_STORE) begin
      if (filt_q) begin
        ipos_q[ch_q]  <= pos_q;
        irate_q[ch_q] <= rate_q;
        est_q[ch_q]   <= somo_pkg::sat32({mrate_cur[SW-1], mrate_cur}
                                         - {pos_q[SW-1], pos_q});
      end else begin
        mpos_q[ch_q]  <= pos_q;
        mrate_q[ch_q] <= rate_q;
      end
    end
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    for (int i = 0; i < somo_pkg::CHANNELS; i++) begin
      est_o[i] = est_q[i];
    end
  end

endmodule

/* src/second_order_momentum_observer_unit.sv */
// A word is accepted only while the sequencer is idle, which works through each channel
// in turn: 10 products on the one shared multiplier plus load, error and store steps,
// then hands the result to the output register, waiting while that register is stalled.
// The next word is taken only after the result is handed over; the first word after
// reset only seeds the state and gives no result. Reset (asynchronous, active
// low) clears the sequencer, restores default gains and empties the output register.
// ----------------------------------------------------------------------------
// Second-order momentum observer
// Three-channel observer: two second-order low-pass filters per channel,
// estimate is the momentum filter rate minus the input filter position.
// ----------------------------------------------------------------------------
module second_order_momentum_observer_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Sample channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [somo_pkg::DATA_W-1:0]  momentum_x_i,
  input  logic signed [somo_pkg::DATA_W-1:0]  momentum_y_i,
  input  logic signed [somo_pkg::DATA_W-1:0]  momentum_z_i,
  input  logic signed [somo_pkg::DATA_W-1:0]  known_x_i,
  input  logic signed [somo_pkg::DATA_W-1:0]  known_y_i,
  input  logic signed [somo_pkg::DATA_W-1:0]  known_z_i,
  input  logic [somo_pkg::DT_W-1:0]           step_time_i,
  // Estimate channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [somo_pkg::DATA_W-1:0]  estimate_x_o,
  output logic signed [somo_pkg::DATA_W-1:0]  estimate_y_o,
  output logic signed [somo_pkg::DATA_W-1:0]  estimate_z_o,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [somo_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [somo_pkg::FREQ_W-1:0]         cfg_data_i
);

  logic [somo_pkg::CHANNELS-1:0][somo_pkg::FREQ_W-1:0] freq;
  logic [somo_pkg::CHANNELS-1:0][somo_pkg::DAMP_W-1:0] damp;
  logic [somo_pkg::CHANNELS-1:0][somo_pkg::DATA_W-1:0] momentum;
  logic [somo_pkg::CHANNELS-1:0][somo_pkg::DATA_W-1:0] known;
  logic [somo_pkg::CHANNELS-1:0][somo_pkg::DATA_W-1:0] est;
  logic [somo_pkg::CHANNELS-1:0][somo_pkg::DATA_W-1:0] out_q;
  somo_pkg::mul_req_t                                  mul_req;
  somo_pkg::mul_rsp_t                                  mul_rsp;
  logic                                                seq_idle;
  logic                                                res_valid;
  logic                                                res_ready;
  logic                                                in_accept;
  logic                                                out_load;
  logic                                                out_valid_q, out_valid_d;

  assign momentum = {momentum_z_i, momentum_y_i, momentum_x_i};
  assign known    = {known_z_i, known_y_i, known_x_i};

  // Take a word whenever the sequencer is idle
  assign in_stall_o = ~seq_idle;
  assign in_accept  = in_valid_i & ~in_stall_o;

  somo_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .freq_o      (freq),
    .damp_o      (damp)
  );

  somo_mul_unit u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  somo_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .momentum_i  (momentum),
    .known_i     (known),
    .step_time_i (step_time_i),
    .freq_i      (freq),
    .damp_i      (damp),
    .mul_req_o   (mul_req),
    .mul_rsp_i   (mul_rsp),
    .idle_o      (seq_idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .est_o       (est)
  );

  // Output register: load when empty or being drained, hold while stalled
  assign res_ready   = ~out_valid_q | ~out_stall_i;
  assign out_load    = res_valid & res_ready;
  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= est;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign estimate_x_o = out_q[0];
  assign estimate_y_o = out_q[1];
  assign estimate_z_o = out_q[2];

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Momentum observer testbench
// Drives sample words into the observer and checks each estimate word
// against an in-bench fixed-point filter predictor. Runs directed corner
// cases, register writes, gain extremes and random traffic under several
// idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;
  import somo_pkg::*;

  localparam int     CLK_PERIOD           = 8;
  localparam int     RESET_CYCLES         = 6;
  localparam int     SETTLE_CYCLES        = 250;
  localparam int     DRAIN_LIMIT_CYCLES   = 20000;
  localparam longint TIMEOUT_CYCLES       = 3_000_000;
  localparam int     MISMATCH_REPORTS     = 10;
  localparam int     RANDOM_PHASE_SAMPLES = 300;
  localparam int     DRAINED_SAMPLES      = 12;
  localparam int     CFG_SLOTS            = 1 << CFG_IDX_W;
  localparam int     REG_UNUSED_BASE      = CFG_DAMP_BASE + CHANNELS;
  localparam int     CH_X                 = 0;
  localparam int     CH_Y                 = 1;
  localparam int     CH_Z                 = 2;

  localparam longint STATE_HI = (longint'(1) <<< (STATE_W - 1)) - 1;
  localparam longint STATE_LO = -STATE_HI - 1;
  localparam longint WORD_HI  = 64'sd2147483647;
  localparam longint WORD_LO  = -64'sd2147483648;

  localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;

  typedef logic [CHANNELS-1:0][DATA_W-1:0] channel_words_t;

  typedef struct packed {
    channel_words_t  momentum;
    channel_words_t  known;
    logic [DT_W-1:0] step;
  } sample_t;

  typedef enum int {
    GAINS_DEFAULT,
    GAINS_ZERO,
    GAINS_MAX,
    GAINS_MIXED
  } gain_style_e;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic signed [DATA_W-1:0]    momentum_x_i;
  logic signed [DATA_W-1:0]    momentum_y_i;
  logic signed [DATA_W-1:0]    momentum_z_i;
  logic signed [DATA_W-1:0]    known_x_i;
  logic signed [DATA_W-1:0]    known_y_i;
  logic signed [DATA_W-1:0]    known_z_i;
  logic [DT_W-1:0]             step_time_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic signed [DATA_W-1:0]    estimate_x_o;
  logic signed [DATA_W-1:0]    estimate_y_o;
  logic signed [DATA_W-1:0]    estimate_z_o;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [CFG_IDX_W-1:0]        cfg_index_i;
  logic [FREQ_W-1:0]           cfg_data_i;

  // Predictor state: gains and the two filters per channel
  logic [FREQ_W-1:0] freq_gain [CHANNELS];
  logic [DAMP_W-1:0] damp_gain [CHANNELS];
  longint            mom_pos   [CHANNELS];
  longint            mom_rate  [CHANNELS];
  longint            inp_pos   [CHANNELS];
  longint            inp_rate  [CHANNELS];
  bit                observer_primed;

  channel_words_t pending_estimates [$];
  int             mismatch_count;
  int             sender_idle_pct;
  int             receiver_stall_pct;

  second_order_momentum_observer_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .momentum_x_i (momentum_x_i),
    .momentum_y_i (momentum_y_i),
    .momentum_z_i (momentum_z_i),
    .known_x_i    (known_x_i),
    .known_y_i    (known_y_i),
    .known_z_i    (known_z_i),
    .step_time_i  (step_time_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .estimate_x_o (estimate_x_o),
    .estimate_y_o (estimate_y_o),
    .estimate_z_o (estimate_z_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Free-running clock
  always begin
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // ------------------------------------------------------------------------
  // Fixed-point predictor
  // ------------------------------------------------------------------------

  function automatic longint clamp48(input longint v);
    if (v > STATE_HI) return STATE_HI;
    if (v < STATE_LO) return STATE_LO;
    return v;
  endfunction

  // Signed times unsigned, shifted right, truncated toward zero, clamped
  function automatic longint scaled_product(input longint a, input logic [63:0] b,
                                            input int shift_bits);
    logic [63:0] lim;
    logic [63:0] mag;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] r;
    bit          neg;
    lim = 64'd1 << (STATE_W - 1);
    neg = (a < 0);
    mag = neg ? 64'(-a) : 64'(a);
    if (mag > lim) mag = lim;
    hi = (mag >> 24) * b;
    lo = (mag & 64'hFF_FFFF) * b;
    if (shift_bits < 24 && hi > (lim >> (24 - shift_bits))) begin
      r = lim;
    end else begin
      r = (hi << (24 - shift_bits)) + (lo >> shift_bits);
    end
    if (r > lim) r = lim;
    return clamp48(neg ? -$signed(r) : $signed(r));
  endfunction

  // One Euler step of a second-order low-pass: rate first, then position
  function automatic void advance_filter(inout longint pos, inout longint rate,
                                         input longint drive, input logic [63:0] wn2,
                                         input logic [63:0] k2, input logic [63:0] dt);
    longint err;
    longint acc;
    err  = clamp48(drive - pos);
    acc  = clamp48(scaled_product(err, wn2, 16) - scaled_product(rate, k2, 16));
    rate = clamp48(rate + scaled_product(acc, dt, 24));
    pos  = clamp48(pos + scaled_product(rate, dt, 24));
  endfunction

  // Advance the observer by one sample; returns 1 when an estimate results
  function automatic bit observe_sample(input sample_t s, output channel_words_t est);
    logic [63:0] dt;
    logic [63:0] wn;
    logic [63:0] wn2;
    logic [63:0] k2;
    longint      diff;
    est = '0;
    // First sample only seeds the momentum filter position
    if (!observer_primed) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        mom_pos[ch]  = longint'($signed(s.momentum[ch]));
        mom_rate[ch] = 0;
        inp_pos[ch]  = 0;
        inp_rate[ch] = 0;
      end
      observer_primed = 1'b1;
      return 1'b0;
    end
    dt = 64'(s.step);
    if (dt < 64'(DT_MIN)) dt = 64'(DT_MIN);
    if (dt > 64'(DT_MAX)) dt = 64'(DT_MAX);
    for (int ch = 0; ch < CHANNELS; ch++) begin
      wn  = 64'(freq_gain[ch]);
      wn2 = wn * wn;
      k2  = 64'd2 * 64'(damp_gain[ch]) * wn;
      advance_filter(mom_pos[ch], mom_rate[ch], longint'($signed(s.momentum[ch])),
                     wn2, k2, dt);
      advance_filter(inp_pos[ch], inp_rate[ch], longint'($signed(s.known[ch])),
                     wn2, k2, dt);
      diff = mom_rate[ch] - inp_pos[ch];
      if (diff > WORD_HI) diff = WORD_HI;
      if (diff < WORD_LO) diff = WORD_LO;
      est[ch] = diff[DATA_W-1:0];
    end
    return 1'b1;
  endfunction

  // ------------------------------------------------------------------------
  // Estimate checking
  // ------------------------------------------------------------------------

  function automatic void note_failure(input string what);
    mismatch_count++;
    if (mismatch_count <= MISMATCH_REPORTS) $display("[%0t] %s", $time, what);
  endfunction

  // Compare each accepted estimate word, then pick the stall for next cycle
  always @(posedge clk_i) begin : estimate_check
    channel_words_t want;
    channel_words_t got;
    got = {estimate_z_o, estimate_y_o, estimate_x_o};
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_estimates.size() == 0) begin
        note_failure($sformatf("unexpected estimate word x=%h y=%h z=%h",
                               got[CH_X], got[CH_Y], got[CH_Z]));
      end else begin
        want = pending_estimates.pop_front();
        for (int ch = 0; ch < CHANNELS; ch++) begin
          if (got[ch] !== want[ch]) begin
            note_failure($sformatf("estimate channel %0d: expected %h, got %h",
                                   ch, want[ch], got[ch]));
          end
        end
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < receiver_stall_pct);
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  // Hand one sample word to the block and record what it should produce
  task automatic send_sample(input sample_t s);
    channel_words_t want;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    momentum_x_i <= s.momentum[CH_X];
    momentum_y_i <= s.momentum[CH_Y];
    momentum_z_i <= s.momentum[CH_Z];
    known_x_i    <= s.known[CH_X];
    known_y_i    <= s.known[CH_Y];
    known_z_i    <= s.known[CH_Z];
    step_time_i  <= s.step;
    do @(posedge clk_i); while (in_stall_o);
    if (observe_sample(s, want)) pending_estimates.push_back(want);
  endtask

  // Drop valid and hold until every expected estimate has arrived
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_estimates.size() != 0);
  endtask

  // Drain, then let the sequencer finish any word that gives no estimate
  task automatic wait_idle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input int idx, input logic [FREQ_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_IDX_W'(idx);
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx >= CFG_FREQ_BASE && idx < CFG_FREQ_BASE + CHANNELS) begin
      freq_gain[idx - CFG_FREQ_BASE] = value;
    end else if (idx >= CFG_DAMP_BASE && idx < CFG_DAMP_BASE + CHANNELS) begin
      damp_gain[idx - CFG_DAMP_BASE] = value[DAMP_W-1:0];
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [FREQ_W-1:0] random_gain(input bit is_damping);
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 20) return '1;
    if (pick < 30) return FREQ_W'($urandom);
    // Moderate gains keep the filters stable; damping carries junk upper bits
    if (is_damping) return {4'($urandom), 12'($urandom_range(32, 1024))};
    return FREQ_W'($urandom_range(128, 8192));
  endfunction

  task automatic load_gains(input gain_style_e style);
    logic [FREQ_W-1:0] value;
    for (int idx = 0; idx < 2 * CHANNELS; idx++) begin
      case (style)
        GAINS_ZERO:    value = '0;
        GAINS_MAX:     value = '1;
        GAINS_DEFAULT: value = (idx < CFG_DAMP_BASE) ? FREQ_RESET : FREQ_W'(DAMP_RESET);
        default:       value = random_gain(idx >= CFG_DAMP_BASE);
      endcase
      write_register(idx, value);
    end
  endtask

  function automatic sample_t uniform_sample(input logic [DATA_W-1:0] m,
                                             input logic [DATA_W-1:0] k,
                                             input logic [DT_W-1:0] step);
    sample_t s;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      s.momentum[ch] = m;
      s.known[ch]    = k;
    end
    s.step = step;
    return s;
  endfunction

  // Mostly moderate values within +-64.0 and in-range steps, some full scale
  function automatic sample_t random_sample();
    sample_t s;
    int      pick;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      s.momentum[ch] = ($urandom_range(99) < 15) ? $urandom
                                                 : $urandom_range(0, 1 << 23) - (1 << 22);
      s.known[ch]    = ($urandom_range(99) < 15) ? $urandom
                                                 : $urandom_range(0, 1 << 23) - (1 << 22);
    end
    pick = $urandom_range(99);
    if (pick < 5) begin
      s.step = DT_W'($urandom_range(0, int'(DT_MIN) - 1));
    end else if (pick < 12) begin
      s.step = DT_W'($urandom_range(int'(DT_MAX) + 1, 24'hFF_FFFF));
    end else if (pick < 50) begin
      s.step = DT_W'($urandom_range(int'(DT_MIN), 8000));
    end else begin
      s.step = DT_W'($urandom_range(int'(DT_MIN), int'(DT_MAX)));
    end
    return s;
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Seed word, then field extremes and step times on both sides of the clamp
  task automatic test_priming_and_extremes();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_sample(uniform_sample(WORD_MAX, WORD_MIN, '0));
    send_sample(uniform_sample('0, '0, DT_MIN));
    send_sample(uniform_sample(WORD_MAX, WORD_MIN, DT_MAX));
    send_sample(uniform_sample(WORD_MIN, WORD_MAX, DT_MAX));
    send_sample(uniform_sample(WORD_MAX, WORD_MAX, '0));
    send_sample(uniform_sample(WORD_MIN, WORD_MIN, DT_MIN - 1'b1));
    send_sample(uniform_sample(32'h0001_0000, 32'hFFFF_0000, DT_MAX + 1'b1));
    send_sample(uniform_sample('0, '0, '1));
    send_sample(uniform_sample('1, 32'd1, 24'h80_0000));
    send_sample(uniform_sample(WORD_MAX, WORD_MIN, DT_MAX));
  endtask

  // Distinct gain per channel, masked damping bits, writes past the map
  task automatic test_register_map();
    wait_idle();
    write_register(CFG_FREQ_BASE + CH_X, 16'd1280);
    write_register(CFG_FREQ_BASE + CH_Y, 16'd5120);
    write_register(CFG_FREQ_BASE + CH_Z, 16'd300);
    write_register(CFG_DAMP_BASE + CH_X, 16'hF100);
    write_register(CFG_DAMP_BASE + CH_Y, 16'h0080);
    write_register(CFG_DAMP_BASE + CH_Z, 16'hA3FF);
    for (int idx = REG_UNUSED_BASE; idx < CFG_SLOTS; idx++) write_register(idx, '1);
    repeat (4) send_sample(random_sample());
  endtask

  task automatic test_zero_gains();
    wait_idle();
    load_gains(GAINS_ZERO);
    send_sample(uniform_sample(32'h0040_0000, 32'hFFC0_0000, DT_MAX));
    send_sample(uniform_sample(WORD_MIN, WORD_MAX, 24'd1000));
    send_sample(uniform_sample('0, '0, DT_MAX));
  endtask

  // Full gains on full-scale swings drive the estimate into saturation
  task automatic test_max_gains();
    wait_idle();
    load_gains(GAINS_MAX);
    send_sample(uniform_sample(WORD_MAX, WORD_MIN, DT_MAX));
    send_sample(uniform_sample(WORD_MIN, WORD_MAX, DT_MAX));
    send_sample(uniform_sample(WORD_MAX, WORD_MAX, DT_MIN));
    send_sample(uniform_sample(WORD_MIN, WORD_MIN, DT_MAX));
  endtask

  // Sender waits for each estimate before offering the next word
  task automatic test_drained_samples();
    wait_idle();
    load_gains(GAINS_DEFAULT);
    repeat (DRAINED_SAMPLES) begin
      send_sample(random_sample());
      hold_until_drained();
    end
  endtask

  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input gain_style_e style);
    wait_idle();
    load_gains(style);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
    repeat (RANDOM_PHASE_SAMPLES) send_sample(random_sample());
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------

  initial begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      freq_gain[ch] = FREQ_RESET;
      damp_gain[ch] = DAMP_RESET;
      mom_pos[ch]   = 0;
      mom_rate[ch]  = 0;
      inp_pos[ch]   = 0;
      inp_rate[ch]  = 0;
    end
    observer_primed    = 1'b0;
    mismatch_count     = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;

    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    momentum_x_i <= '0;
    momentum_y_i <= '0;
    momentum_z_i <= '0;
    known_x_i    <= '0;
    known_y_i    <= '0;
    known_z_i    <= '0;
    step_time_i  <= '0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= '0;
    cfg_data_i   <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_priming_and_extremes();
    test_register_map();
    test_zero_gains();
    test_max_gains();
    test_drained_samples();
    test_random_traffic(0, 0, GAINS_MIXED);
    test_random_traffic(88, 0, GAINS_MIXED);
    test_random_traffic(0, 88, GAINS_DEFAULT);
    test_random_traffic(36, 36, GAINS_MIXED);

    // Let the last estimates arrive, bounded
    in_valid_i <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT_CYCLES && pending_estimates.size() != 0; n++) begin
      @(posedge clk_i);
    end
    if (pending_estimates.size() != 0) begin
      note_failure($sformatf("%0d estimate words never arrived", pending_estimates.size()));
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* second_order_momentum_observer_unit.f */
src/somo_pkg.sv
src/somo_cfg_regs.sv
src/somo_mul_unit.sv
src/somo_seq.sv
src/second_order_momentum_observer_unit.sv
tb/testbench.sv
